@@ sv/vie_pkg.sv @@
`default_nettype none
package vie_pkg;
  localparam int MaxPointsDef = 8;
  localparam int FracBitsDef  = 16;
  localparam logic [3:0] PointCountRst = 4'd6;
  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncSolve = 1'b1;
  localparam logic KindCoeff = 1'b0;
  localparam logic KindValue = 1'b1;
  localparam logic signed [31:0] SatMax = 32'sh7fffffff;
  localparam logic signed [31:0] SatMin = -32'sh7fffffff - 32'sd1;

  function automatic logic signed [31:0] sat64(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'(SatMax)) r = SatMax;
    else if (v < 66'(SatMin)) r = SatMin;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/vie_ram.sv @@
`default_nettype none
module vie_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/vie_div.sv @@
`default_nettype none
// signed restoring divider: q = sat((num << FracBits) / den), trunc toward zero
module vie_div import vie_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic signed [31:0] num,
  input  wire logic signed [32:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  localparam int NW = 32 + FracBits;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] dvd_r, q_r;
  logic [33:0]   rem_r, dv_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r, run_r;
  logic [34:0]   trial;
  logic [NW:0]   qs;
  logic [NW-1:0] an;
  logic [32:0]   ad;
  assign an = num[31] ? NW'(-(NW'($signed(num)) <<< FracBits))
                      : NW'(NW'($signed(num)) <<< FracBits);
  assign ad = den[32] ? 33'(-den) : 33'(den);
  assign trial = {rem_r, dvd_r[NW-1]} - {1'b0, dv_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        dvd_r <= an;
        dv_r  <= {1'b0, ad};
        rem_r <= '0;
        q_r   <= '0;
        neg_r <= num[31] ^ den[32];
        cnt_r <= CW'(NW);
      end else if (run_r) begin
        if (!trial[34]) begin
          rem_r <= trial[33:0];
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[32:0], dvd_r[NW-1]};
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        dvd_r <= {dvd_r[NW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end
  assign qs = neg_r ? -{1'b0, q_r} : {1'b0, q_r};
  always_comb begin
    if (!neg_r && q_r > NW'(SatMax)) quo = SatMax;
    else if (neg_r && q_r > NW'(33'h80000000)) quo = SatMin;
    else quo = qs[31:0];
  end
endmodule
`default_nettype wire

@@ sv/vandermonde_interpolate_eval.sv @@
`default_nettype none
// Vandermonde interpolation / evaluation.
// Input: pulse start with in_func/in_x_value/in_y_value while busy is low.
//   in_func=0 stores one (x,y) pair; busy stays low, so loads
//   can go back to back; ignored when store full.
//   in_func=1 solves on the first point_count pairs (clamped 2..MAX_POINTS)
//   and evaluates at in_x_value.
// Output: each beat is shown for one cycle with out_valid: n coefficients
//   (degree 0 first) then the value beat with out_last.
//   Receiver cannot stall.
// Config: cfg_valid/cfg_ready writes point_count; write only while idle.
// Compute: each divided difference runs on the one serial divider, which is
//   skipped when the two x values are equal; each multiply-subtract and each
//   Horner step runs on the shared multiplier. Busy holds until the value
//   beat, and the next input can be accepted in the cycle it is shown.
// Reset: loaded count clears, point_count returns to 6; stores are
//   undefined until loaded.
module vandermonde_interpolate_eval import vie_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_func,
  input  wire logic signed [31:0] in_x_value,
  input  wire logic signed [31:0] in_y_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_point_count,
  output logic                    out_valid,
  output logic                    out_kind,
  output logic [2:0]              out_coeff_index,
  output logic signed [31:0]      out_result_value,
  output logic                    out_divide_by_zero,
  output logic                    out_last
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DRD, S_DRD2, S_DDIV, S_NRD, S_NRD2, S_NMUL, S_NWR,
    S_OUT, S_ORD, S_HRD, S_HMUL, S_HADD, S_VOUT
  } state_t;

  state_t state_r;
  logic [3:0] pc_r;
  logic [CW-1:0] loaded_r, n_r;
  logic [AW-1:0] k_r, j_r;
  logic dz_r;
  logic signed [31:0] acc_r, qx_r, wa_r, xa_r;
  logic signed [63:0] prod_r;

  logic          xwe, wwe;
  logic [AW-1:0] xwa, wwa, xra, wra;
  logic [31:0]   xwd, wwd, xrd, wrd;

  vie_ram #(.Width(32), .Depth(MAX_POINTS)) u_xram (
    .clk(clk), .we(xwe), .waddr(xwa), .wdata(xwd), .raddr(xra), .rdata(xrd));
  vie_ram #(.Width(32), .Depth(MAX_POINTS)) u_wram (
    .clk(clk), .we(wwe), .waddr(wwa), .wdata(wwd), .raddr(wra), .rdata(wrd));

  logic div_go, div_done;
  logic signed [31:0] div_num, div_q;
  logic signed [32:0] div_den;
  vie_div #(.FracBits(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q));

  // phase bit: clear on entry to S_DDIV, where the divider is started or a zero denominator is caught
  logic ph_r;
  logic accept;
  logic [CW-1:0] nclamp;
  logic signed [63:0] fl;
  logic signed [32:0] den_w;

  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  always_comb begin
    if (pc_r < 4'd2) nclamp = CW'(2);
    else if ({28'd0, pc_r} > 32'(MAX_POINTS)) nclamp = CW'(MAX_POINTS);
    else nclamp = CW'(pc_r);
  end
  assign fl = prod_r >>> FRAC_BITS;
  assign den_w = 33'($signed(xa_r)) - 33'($signed(xrd));

  always_comb begin
    xwe = 1'b0; wwe = 1'b0;
    xwa = loaded_r[AW-1:0]; wwa = loaded_r[AW-1:0];
    xwd = in_x_value; wwd = in_y_value;
    xra = j_r; wra = j_r;
    div_go = 1'b0;
    div_num = sat64(66'($signed(wa_r)) - 66'($signed(wrd)));
    div_den = den_w;
    if (accept && in_func == FuncLoad && loaded_r < CW'(MAX_POINTS)) begin
      xwe = 1'b1; wwe = 1'b1;
    end
    case (state_r)
      S_DRD:  begin xra = j_r; wra = j_r; end
      S_DRD2: begin xra = AW'(j_r - k_r - 1'b1); wra = AW'(j_r - 1'b1); end
      S_DDIV: begin
        if (ph_r == 1'b0 && den_w != '0) div_go = 1'b1;
        wwa = j_r;
        wwd = div_done ? div_q : 32'd0;
        wwe = (ph_r == 1'b0 && den_w == '0) || div_done;
      end
      S_NRD:  begin xra = k_r; wra = AW'(j_r + 1'b1); end
      S_NRD2: begin wra = j_r; end
      S_NWR:  begin
        wwa = j_r;
        wwd = sat64(66'($signed(wrd)) - 66'(fl));
        wwe = 1'b1;
      end
      S_OUT, S_ORD: wra = j_r;
      S_HRD:  wra = j_r;
      default: ;
    endcase
  end

  logic signed [31:0] mul_a, mul_b;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= PointCountRst;
      loaded_r <= '0;
      out_valid <= 1'b0;
      ph_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) pc_r <= cfg_point_count;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_func == FuncLoad) begin
              if (loaded_r < CW'(MAX_POINTS)) loaded_r <= loaded_r + 1'b1;
            end else begin
              n_r <= nclamp; qx_r <= in_x_value; dz_r <= 1'b0;
              k_r <= '0; j_r <= AW'(nclamp - 1'b1);
              state_r <= S_DRD;
            end
          end
        end
        S_DRD: state_r <= S_DRD2;
        S_DRD2: begin
          xa_r <= xrd; wa_r <= wrd; ph_r <= 1'b0; state_r <= S_DDIV;
        end
        S_DDIV: begin
          ph_r <= 1'b1;
          if ((ph_r == 1'b0 && den_w == '0) || div_done) begin
            if (ph_r == 1'b0 && den_w == '0) dz_r <= 1'b1;
            if (j_r > AW'(k_r + 1'b1)) begin
              j_r <= j_r - 1'b1; state_r <= S_DRD;
            end else if ({1'b0, k_r} + 2'd2 < (AW+1)'(n_r)) begin
              k_r <= k_r + 1'b1; j_r <= AW'(n_r - 1'b1); state_r <= S_DRD;
            end else begin
              k_r <= AW'(n_r - 2'd2); j_r <= AW'(n_r - 2'd2); state_r <= S_NRD;
            end
          end
        end
        S_NRD: state_r <= S_NRD2;
        S_NRD2: begin
          mul_a <= xrd; mul_b <= wrd;
          state_r <= S_NMUL;
        end
        S_NMUL: begin prod_r <= mul_a * mul_b; state_r <= S_NWR; end
        S_NWR: begin
          if ({1'b0, j_r} + 2'd2 < (AW+1)'(n_r)) begin
            j_r <= j_r + 1'b1; state_r <= S_NRD;
          end else if (k_r != '0) begin
            k_r <= k_r - 1'b1; j_r <= k_r - 1'b1; state_r <= S_NRD;
          end else begin
            j_r <= '0; state_r <= S_OUT;
          end
        end
        S_OUT: state_r <= S_ORD;
        S_ORD: begin
          out_valid <= 1'b1; out_kind <= KindCoeff;
          out_coeff_index <= 3'(j_r); out_result_value <= wrd;
          out_divide_by_zero <= dz_r; out_last <= 1'b0;
          if ({1'b0, j_r} + 1'b1 < (AW+1)'(n_r)) begin
            j_r <= j_r + 1'b1; state_r <= S_OUT;
          end else begin
            acc_r <= wrd; j_r <= AW'(n_r - 2'd2); state_r <= S_HRD;
          end
        end
        S_HRD: begin
          mul_a <= acc_r; mul_b <= qx_r; state_r <= S_HMUL;
        end
        S_HMUL: begin prod_r <= mul_a * mul_b; state_r <= S_HADD; end
        S_HADD: begin
          acc_r <= sat64(66'(fl) + 66'($signed(wrd)));
          if (j_r != '0) begin
            j_r <= j_r - 1'b1; state_r <= S_HRD;
          end else state_r <= S_VOUT;
        end
        S_VOUT: begin
          out_valid <= 1'b1; out_kind <= KindValue; out_coeff_index <= '0;
          out_result_value <= acc_r; out_divide_by_zero <= dz_r;
          out_last <= 1'b1; loaded_r <= '0; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/vie_checker.sv @@
`default_nettype none
module vie_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_kind,
  input wire logic out_last
);
  a_last_is_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind) else $error("last without value");
  a_value_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last) else $error("value not last");
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("busy after last");
  a_beats_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy) else $error("beat while idle");
endmodule

bind vandermonde_interpolate_eval vie_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_kind(out_kind), .out_last(out_last));
`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;
  import vie_pkg::*;

  typedef struct {
    logic        kind;
    logic [2:0]  idx;
    logic [31:0] value;
    logic        dz;
    logic        last;
  } beat_t;

  typedef struct {
    logic        func;
    logic [31:0] x;
    logic [31:0] y;
    bit          chk;
    logic [31:0] val;
    logic        dz;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_func = FuncLoad;
  logic signed [31:0] in_x_value = '0;
  logic signed [31:0] in_y_value = '0;
  logic cfg_valid = 1'b0;
  logic [3:0] cfg_point_count = '0;
  logic busy, cfg_ready, out_valid, out_kind, out_divide_by_zero, out_last;
  logic [2:0] out_coeff_index;
  logic signed [31:0] out_result_value;

  vandermonde_interpolate_eval dut (
    .clk, .rst_n, .start, .busy, .in_func, .in_x_value, .in_y_value,
    .cfg_valid, .cfg_ready, .cfg_point_count, .out_valid, .out_kind,
    .out_coeff_index, .out_result_value, .out_divide_by_zero, .out_last
  );

  always #5 clk = ~clk;

  longint xs[MaxPointsDef];
  longint ws[MaxPointsDef];
  int unsigned loaded = 0;
  logic [3:0] pcount = PointCountRst;
  beat_t pending[$];
  row_t dir_tab[$];
  int errors = 0;
  int n_items = 0, n_solves = 0, n_beats = 0, n_dz = 0;
  longint cycles = 0;
  logic [3:0] cfgs[10] = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd9, 4'd5, 4'd7, 4'd4};

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    return (a * b) >>> FracBitsDef;
  endfunction

  function automatic int eff_n();
    int n;
    n = pcount;
    if (n < 2) n = 2;
    if (n > MaxPointsDef) n = MaxPointsDef;
    return n;
  endfunction

  function automatic void solve_predict(logic func, logic signed [31:0] x,
                                        logic signed [31:0] y);
    int n;
    bit dz;
    longint num, den, r;
    beat_t b;
    dz = 0;
    if (func == FuncLoad) begin
      if (loaded < MaxPointsDef) begin
        xs[loaded] = x;
        ws[loaded] = y;
        loaded++;
      end
      return;
    end
    n = eff_n();
    for (int k = 0; k < n - 1; k++)
      for (int j = n - 1; j > k; j--) begin
        num = sat32(ws[j] - ws[j-1]);
        den = xs[j] - xs[j-k-1];
        if (den == 0) begin
          dz = 1;
          ws[j] = 0;
        end else begin
          ws[j] = sat32((num * 65536) / den);
        end
      end
    for (int k = n - 2; k >= 0; k--)
      for (int j = k; j < n - 1; j++)
        ws[j] = sat32(ws[j] - fxmul(xs[k], ws[j+1]));
    for (int i = 0; i < n; i++) begin
      b.kind = KindCoeff; b.idx = i[2:0]; b.value = ws[i][31:0];
      b.dz = dz; b.last = 1'b0;
      pending.push_back(b);
    end
    r = ws[n-1];
    for (int i = n - 2; i >= 0; i--) r = sat32(fxmul(r, longint'(x)) + ws[i]);
    b.kind = KindValue; b.idx = '0; b.value = r[31:0]; b.dz = dz; b.last = 1'b1;
    pending.push_back(b);
    loaded = 0;
    n_solves++;
    if (dz) n_dz++;
  endfunction

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid) begin
      n_beats++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat value=%h", $time, out_result_value);
      end else begin
        e = pending.pop_front();
        if (out_kind !== e.kind || out_coeff_index !== e.idx ||
            out_result_value !== e.value || out_divide_by_zero !== e.dz ||
            out_last !== e.last) begin
          errors++;
          $display("%0t: mismatch exp kind=%0d idx=%0d val=%h dz=%0d last=%0d",
                   $time, e.kind, e.idx, e.value, e.dz, e.last);
          $display("%0t:          got kind=%0d idx=%0d val=%h dz=%0d last=%0d",
                   $time, out_kind, out_coeff_index, out_result_value,
                   out_divide_by_zero, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("vandermonde_interpolate_eval regression: fail");
      $finish;
    end
  end

  task automatic send(logic func, logic [31:0] x, logic [31:0] y,
                      bit chk = 0, logic [31:0] val = '0, logic dz = 1'b0);
    int gap;
    int base;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_x_value <= x;
    in_y_value <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    base = pending.size();
    solve_predict(func, x, y);
    if (chk)
      for (int i = base; i < pending.size(); i++) begin
        pending[i].value = val;
        pending[i].dz = dz;
      end
    n_items++;
  endtask

  task automatic write_cfg(logic [3:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_point_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pcount = v;
  endtask

  function automatic void add_row(logic func, logic [31:0] x, logic [31:0] y,
                                  bit chk = 0, logic [31:0] val = '0,
                                  logic dz = 1'b0);
    row_t r;
    r.func = func; r.x = x; r.y = y; r.chk = chk; r.val = val; r.dz = dz;
    dir_tab.push_back(r);
  endfunction

  function automatic logic [31:0] rand_val(int scale);
    logic [31:0] v;
    v = $urandom();
    case (scale)
      0: v = 32'(signed'(v[19:0]));
      1: v = 32'(signed'(v[23:0]));
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_seq();
    int n, cnt, scale, mode;
    logic [31:0] x;
    n = eff_n();
    mode = $urandom_range(0, 9);
    scale = $urandom_range(0, 2);
    cnt = n;
    if (mode == 0) cnt = n + $urandom_range(1, 3);
    else if (mode == 1) cnt = $urandom_range(0, n);
    for (int i = 0; i < cnt; i++) begin
      x = (scale == 0) ? 32'(($urandom_range(0, 15) - 8) <<< 16) + $urandom_range(0, 3)
                       : rand_val(scale);
      if (mode == 2 && i > 0 && $urandom_range(0, 2) == 0) x = xs[0][31:0];
      send(FuncLoad, x, rand_val(scale));
    end
    if (mode == 3) send(1'($urandom_range(0, 1)), $urandom(), $urandom());
    send(FuncSolve, rand_val($urandom_range(0, 2)), $urandom());
  endtask

  initial begin
    for (int i = 0; i < 8; i++) add_row(FuncLoad, 32'(i) << 16, '0);
    add_row(FuncSolve, SatMax, $urandom(), 1, '0, 1'b0);
    for (int i = 0; i < 6; i++) add_row(FuncLoad, SatMin, '0);
    add_row(FuncSolve, 32'h0001_0000, '0, 1, '0, 1'b1);
    for (int i = 0; i < 9; i++)
      add_row(FuncLoad, i[0] ? SatMax - i : SatMin + i, i[0] ? SatMax : SatMin);
    add_row(FuncSolve, SatMin, SatMax);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i])
      send(dir_tab[i].func, dir_tab[i].x, dir_tab[i].y,
           dir_tab[i].chk, dir_tab[i].val, dir_tab[i].dz);

    foreach (cfgs[p]) begin
      write_cfg(cfgs[p]);
      for (int s = n_items + 25; n_items < s; ) random_seq();
    end
    write_cfg(PointCountRst);
    repeat (4) random_seq();

    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d items sent over 11 point_count settings (clamped ends included);",
             n_items);
    $display("%0d solves, %0d of them with repeated x; %0d beats, %0d errors",
             n_solves, n_dz, n_beats, errors);
    if (errors == 0) $display("vandermonde_interpolate_eval regression: pass");
    else $display("vandermonde_interpolate_eval regression: fail");
    $finish;
  end
endmodule
